// ===== rtl/core/gamepad_input_conditioning_defines.svh =====
// assertion macros for the gamepad input conditioning checker
// expects clk and rst_n in the scope of use
`ifndef GAMEPAD_INPUT_CONDITIONING_DEFINES_SVH
`define GAMEPAD_INPUT_CONDITIONING_DEFINES_SVH

// same-cycle implication, off while reset is low
`define GIC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is low
`define GIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gic_pkg.sv =====
// shared constants, types and reset values for gamepad input conditioning
// no dependencies
package gic_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int SW           = SAMPLE_BITS + 1;
  localparam int NUM_CAL      = 4;
  localparam int CAL_BITS     = NUM_CAL * SAMPLE_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int BYTE_BITS    = 8;
  localparam int LOW_PINS     = 10;
  localparam int HIGH_PINS    = 4;
  localparam int BUTTON_BITS  = 16;
  localparam int NUM_TRIG     = 2;

  localparam int PREP_STAGES  = 2;
  localparam int DIV_STAGES   = 5;
  localparam int DIV_STEPS    = 4;
  localparam int QUOT_BITS    = DIV_STAGES * DIV_STEPS;
  localparam int LANE_STAGES  = PREP_STAGES + DIV_STAGES;

  localparam int SCALE_SHIFT  = 7;
  localparam logic [BYTE_BITS-1:0] CENTRE = BYTE_BITS'(2 ** SCALE_SHIFT - 1);

  localparam logic [SAMPLE_BITS-1:0] TRIG_HIGH  = SAMPLE_BITS'(1870);
  localparam logic [SAMPLE_BITS-1:0] TRIG_LOW   = SAMPLE_BITS'(500);
  localparam int                     TRIG_DIV   = 11;
  localparam int                     TRIG_SHIFT = 15;
  localparam int                     TRIG_PROD_BITS = 2 * SAMPLE_BITS + 1;
  localparam logic [SAMPLE_BITS-1:0] TRIG_RECIP =
    SAMPLE_BITS'((2 ** TRIG_SHIFT + TRIG_DIV - 1) / TRIG_DIV);
  localparam logic [BYTE_BITS-1:0]   TRIG_OUT_MAX =
    BYTE_BITS'((1870 - 500) * 2 / TRIG_DIV);
  localparam logic [BYTE_BITS-1:0]   PRESS_LEVEL_RST = BYTE_BITS'(70);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CAL_LX     = 3'd0,
    REG_CAL_LY     = 3'd1,
    REG_CAL_RX     = 3'd2,
    REG_CAL_RY     = 3'd3,
    REG_TRIG_LEVEL = 3'd4
  } cfg_reg_t;

  // fields: min 47:36, dead-zone low 35:24, dead-zone high 23:12, max 11:0
  typedef logic [CAL_BITS-1:0] cal_t;

  localparam cal_t CAL_RST [NUM_CAL] = '{
    {12'd700, 12'd1730, 12'd2130, 12'd3000},
    {12'd500, 12'd1830, 12'd1925, 12'd3312},
    {12'd700, 12'd1844, 12'd1998, 12'd3442},
    {12'd500, 12'd1871, 12'd1936, 12'd3314}
  };

  typedef struct packed {
    logic [LANE_STAGES-1:0] load;
    logic                   out_load;
  } pipe_ctl_t;

endpackage

// ===== rtl/core/gic_stick_lane.sv =====
// one stick axis lane: clamp, region select, scaling by a pipelined divider
// depends on gic_pkg
module gic_stick_lane (
  input  logic                                  clk,
  input  gic_pkg::pipe_ctl_t                    ctl,
  input  logic [gic_pkg::SAMPLE_BITS-1:0]       raw,
  input  gic_pkg::cal_t                         cal,
  output logic [gic_pkg::BYTE_BITS-1:0]         stick
);

  localparam int SB = gic_pkg::SAMPLE_BITS;
  localparam int SW = gic_pkg::SW;
  localparam int QB = gic_pkg::QUOT_BITS;
  localparam int DS = gic_pkg::DIV_STAGES;
  localparam int BB = gic_pkg::BYTE_BITS;

  logic signed [SW-1:0] x, mx, hi, lo, mn, xc;
  logic signed [SW-1:0] nd_nxt, dd_nxt;
  logic                 off_nxt, ctr_nxt;

  logic signed [SW-1:0] nd_r, dd_r;
  logic                 off1_r, ctr1_r;

  logic [SW-1:0]        nabs, dabs;
  logic [SB-1:0]        nmag, dmag;
  logic [QB-1:0]        prod;

  logic [QB-1:0]        nq_r  [DS+1];
  logic [SB-1:0]        rem_r [DS+1];
  logic [SB-1:0]        d_r   [DS+1];
  logic                 neg_r [DS+1];
  logic                 off_r [DS+1];
  logic                 ctr_r [DS+1];

  logic [BB-1:0]        q8, sq, v;

  assign x  = $signed({1'b0, raw});
  assign mx = $signed({1'b0, cal[SB-1:0]});
  assign hi = $signed({1'b0, cal[2*SB-1:SB]});
  assign lo = $signed({1'b0, cal[3*SB-1:2*SB]});
  assign mn = $signed({1'b0, cal[4*SB-1:3*SB]});

  // clamp against max first, then min; pick the region
  always_comb begin
    xc      = x;
    nd_nxt  = '0;
    dd_nxt  = '0;
    off_nxt = 1'b0;
    ctr_nxt = 1'b1;
    priority if (x > mx) begin
      xc = mx;
    end else if (x < mn) begin
      xc = mn;
    end else begin
      xc = x;
    end
    priority if (xc > hi) begin
      ctr_nxt = (mx == hi);
      nd_nxt  = xc - hi;
      dd_nxt  = mx - hi;
      off_nxt = 1'b1;
    end else if (xc < lo) begin
      ctr_nxt = (lo == mn);
      nd_nxt  = xc - mn;
      dd_nxt  = lo - mn;
    end else begin
      ctr_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      nd_r   <= nd_nxt;
      dd_r   <= dd_nxt;
      off1_r <= off_nxt;
      ctr1_r <= ctr_nxt;
    end
  end

  // magnitudes and the scale by 127 as shift and subtract
  assign nabs = nd_r[SW-1] ? SW'(-nd_r) : nd_r;
  assign dabs = dd_r[SW-1] ? SW'(-dd_r) : dd_r;
  assign nmag = nabs[SB-1:0];
  assign dmag = dabs[SB-1:0];
  assign prod = QB'({nmag, gic_pkg::SCALE_SHIFT'(0)}) - QB'(nmag);

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      nq_r[0]  <= prod;
      rem_r[0] <= '0;
      d_r[0]   <= dmag;
      neg_r[0] <= nd_r[SW-1] ^ dd_r[SW-1];
      off_r[0] <= off1_r;
      ctr_r[0] <= ctr1_r;
    end
  end

  // restoring division, a few quotient bits per stage
  for (genvar j = 1; j <= DS; j++) begin : g_div
    logic [QB-1:0] nq;
    logic [SB:0]   rem;

    always_comb begin
      nq  = nq_r[j-1];
      rem = {1'b0, rem_r[j-1]};
      for (int s = 0; s < gic_pkg::DIV_STEPS; s++) begin
        rem = {rem[SB-1:0], nq[QB-1]};
        nq  = {nq[QB-2:0], 1'b0};
        if (rem >= {1'b0, d_r[j-1]}) begin
          rem   = rem - {1'b0, d_r[j-1]};
          nq[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.load[gic_pkg::PREP_STAGES-1+j]) begin
        nq_r[j]  <= nq;
        rem_r[j] <= rem[SB-1:0];
        d_r[j]   <= d_r[j-1];
        neg_r[j] <= neg_r[j-1];
        off_r[j] <= off_r[j-1];
        ctr_r[j] <= ctr_r[j-1];
      end
    end
  end

  // sign, offset and centre on the low byte only
  assign q8    = nq_r[DS][BB-1:0];
  assign sq    = neg_r[DS] ? BB'(-q8) : q8;
  assign v     = sq + (off_r[DS] ? gic_pkg::CENTRE : BB'(0));
  assign stick = ctr_r[DS] ? gic_pkg::CENTRE : v;

endmodule

// ===== rtl/core/gic_trig_lane.sv =====
// one trigger lane: clamp, inverse scale by reciprocal multiply, delay taps
// depends on gic_pkg
module gic_trig_lane (
  input  logic                            clk,
  input  gic_pkg::pipe_ctl_t              ctl,
  input  logic [gic_pkg::SAMPLE_BITS-1:0] raw,
  output logic [gic_pkg::BYTE_BITS-1:0]   trig
);

  localparam int SB = gic_pkg::SAMPLE_BITS;
  localparam int BB = gic_pkg::BYTE_BITS;
  localparam int PB = gic_pkg::TRIG_PROD_BITS;
  localparam int LS = gic_pkg::LANE_STAGES;

  logic [SB-1:0] xc, diff;
  logic [PB-1:0] prod;
  logic [BB-1:0] tb_nxt;
  logic [BB-1:0] tq_r [LS];

  always_comb begin
    xc = raw;
    priority if (raw > gic_pkg::TRIG_HIGH) begin
      xc = gic_pkg::TRIG_HIGH;
    end else if (raw < gic_pkg::TRIG_LOW) begin
      xc = gic_pkg::TRIG_LOW;
    end else begin
      xc = raw;
    end
  end

  assign diff   = gic_pkg::TRIG_HIGH - xc;
  assign prod   = PB'({diff, 1'b0}) * PB'(gic_pkg::TRIG_RECIP);
  assign tb_nxt = prod[gic_pkg::TRIG_SHIFT +: BB];

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      tq_r[0] <= tb_nxt;
    end
  end

  for (genvar k = 1; k < LS; k++) begin : g_tap
    always_ff @(posedge clk) begin
      if (ctl.load[k]) begin
        tq_r[k] <= tq_r[k-1];
      end
    end
  end

  assign trig = tq_r[LS-1];

endmodule

// ===== rtl/core/gic_merge.sv =====
// merging stage: pin delay taps, button word assembly and output register
// depends on gic_pkg
module gic_merge (
  input  logic                              clk,
  input  gic_pkg::pipe_ctl_t                ctl,
  input  logic [gic_pkg::LOW_PINS-1:0]      low_pins,
  input  logic [gic_pkg::HIGH_PINS-1:0]     high_pins,
  input  logic [gic_pkg::BYTE_BITS-1:0]     stick [gic_pkg::NUM_CAL],
  input  logic [gic_pkg::BYTE_BITS-1:0]     trig  [gic_pkg::NUM_TRIG],
  input  logic [gic_pkg::BYTE_BITS-1:0]     press_level,
  output logic [gic_pkg::BYTE_BITS-1:0]     stick_out [gic_pkg::NUM_CAL],
  output logic [gic_pkg::BYTE_BITS-1:0]     trig_out  [gic_pkg::NUM_TRIG],
  output logic [gic_pkg::BUTTON_BITS-1:0]   button_word
);

  localparam int LS = gic_pkg::LANE_STAGES;
  localparam int PW = gic_pkg::LOW_PINS + gic_pkg::HIGH_PINS;

  logic [PW-1:0]                     pins_r [LS];
  logic [gic_pkg::BUTTON_BITS-1:0]   button_nxt;
  logic [gic_pkg::BYTE_BITS-1:0]     stick_r [gic_pkg::NUM_CAL];
  logic [gic_pkg::BYTE_BITS-1:0]     trig_r  [gic_pkg::NUM_TRIG];
  logic [gic_pkg::BUTTON_BITS-1:0]   button_r;

  // pins stored already in pressed-high form
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      pins_r[0] <= {high_pins, ~low_pins};
    end
  end

  for (genvar k = 1; k < LS; k++) begin : g_tap
    always_ff @(posedge clk) begin
      if (ctl.load[k]) begin
        pins_r[k] <= pins_r[k-1];
      end
    end
  end

  assign button_nxt = {trig[1] > press_level, trig[0] > press_level, pins_r[LS-1]};

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      stick_r  <= stick;
      trig_r   <= trig;
      button_r <= button_nxt;
    end
  end

  assign stick_out   = stick_r;
  assign trig_out    = trig_r;
  assign button_word = button_r;

endmodule

// ===== rtl/core/gamepad_input_conditioning.sv =====
// gamepad input conditioning: six sample lanes and the merging output stage
// depends on gic_pkg, gic_stick_lane, gic_trig_lane and gic_merge
//
// One transfer on the input channel carries a snapshot of four stick samples,
// two trigger samples and fourteen button pins; one transfer on the output
// channel carries the matching four stick bytes, two trigger bytes and the
// 16-bit button word. Results leave in the order the snapshots came in.
// Each snapshot passes the two preparation stages and the five divider stages
// of each stick lane (four quotient bits per stage), then the output register.
// Throughput is one snapshot per cycle while in_stall is low.
// When out_stall holds a result, the stages behind it keep filling until the
// pipeline is full; only then does in_stall rise.
// The cfg channel is always ready; index 0..3 load the stick calibrations,
// index 4 the trigger press level, other indices are dropped. Write it only
// when no snapshot is in flight.
// A synchronous reset empties the pipeline and restores the calibration and
// press level defaults; no clearing pass is needed.
module gamepad_input_conditioning (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gic_pkg::SAMPLE_BITS-1:0]     in_raw_lx,
  input  logic [gic_pkg::SAMPLE_BITS-1:0]     in_raw_ly,
  input  logic [gic_pkg::SAMPLE_BITS-1:0]     in_raw_rx,
  input  logic [gic_pkg::SAMPLE_BITS-1:0]     in_raw_ry,
  input  logic [gic_pkg::SAMPLE_BITS-1:0]     in_raw_ltrig,
  input  logic [gic_pkg::SAMPLE_BITS-1:0]     in_raw_rtrig,
  input  logic [gic_pkg::LOW_PINS-1:0]        in_low_active_pins,
  input  logic [gic_pkg::HIGH_PINS-1:0]       in_high_active_pins,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gic_pkg::BYTE_BITS-1:0]       out_stick_lx,
  output logic [gic_pkg::BYTE_BITS-1:0]       out_stick_ly,
  output logic [gic_pkg::BYTE_BITS-1:0]       out_stick_rx,
  output logic [gic_pkg::BYTE_BITS-1:0]       out_stick_ry,
  output logic [gic_pkg::BYTE_BITS-1:0]       out_trig_left,
  output logic [gic_pkg::BYTE_BITS-1:0]       out_trig_right,
  output logic [gic_pkg::BUTTON_BITS-1:0]     out_button_word,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gic_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [gic_pkg::CAL_BITS-1:0]        cfg_data
);

  localparam int LS = gic_pkg::LANE_STAGES;
  localparam int SB = gic_pkg::SAMPLE_BITS;
  localparam int BB = gic_pkg::BYTE_BITS;

  gic_pkg::cal_t       cal_r [gic_pkg::NUM_CAL];
  logic [BB-1:0]       level_r;

  logic [LS-1:0]       vld_r, vld_nxt, rdy, src;
  logic                out_valid_r, out_valid_nxt, out_rdy;
  gic_pkg::pipe_ctl_t  ctl;

  logic [SB-1:0]       raw_stick [gic_pkg::NUM_CAL];
  logic [SB-1:0]       raw_trig  [gic_pkg::NUM_TRIG];
  logic [BB-1:0]       stick     [gic_pkg::NUM_CAL];
  logic [BB-1:0]       trig      [gic_pkg::NUM_TRIG];
  logic [BB-1:0]       stick_o   [gic_pkg::NUM_CAL];
  logic [BB-1:0]       trig_o    [gic_pkg::NUM_TRIG];

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r   <= gic_pkg::CAL_RST;
      level_r <= gic_pkg::PRESS_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gic_pkg::REG_CAL_LX:     cal_r[0] <= cfg_data;
        gic_pkg::REG_CAL_LY:     cal_r[1] <= cfg_data;
        gic_pkg::REG_CAL_RX:     cal_r[2] <= cfg_data;
        gic_pkg::REG_CAL_RY:     cal_r[3] <= cfg_data;
        gic_pkg::REG_TRIG_LEVEL: level_r  <= cfg_data[BB-1:0];
        default: ;
      endcase
    end
  end

  // stage valids with bubble collapsing
  always_comb begin
    out_rdy    = !out_valid_r || !out_stall;
    rdy[LS-1]  = !vld_r[LS-1] || out_rdy;
    for (int k = LS - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign src = {vld_r[LS-2:0], in_valid};

  always_comb begin
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    for (int k = 0; k < LS; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = src[k];
      end
    end
    if (out_rdy) begin
      out_valid_nxt = vld_r[LS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign ctl.load     = rdy & src;
  assign ctl.out_load = out_rdy && vld_r[LS-1];

  assign in_stall  = !rdy[0];
  assign out_valid = out_valid_r;

  // lanes
  assign raw_stick[0] = in_raw_lx;
  assign raw_stick[1] = in_raw_ly;
  assign raw_stick[2] = in_raw_rx;
  assign raw_stick[3] = in_raw_ry;
  assign raw_trig[0]  = in_raw_ltrig;
  assign raw_trig[1]  = in_raw_rtrig;

  for (genvar i = 0; i < gic_pkg::NUM_CAL; i++) begin : g_stick
    gic_stick_lane u_stick (
      .clk   (clk),
      .ctl   (ctl),
      .raw   (raw_stick[i]),
      .cal   (cal_r[i]),
      .stick (stick[i])
    );
  end

  for (genvar i = 0; i < gic_pkg::NUM_TRIG; i++) begin : g_trig
    gic_trig_lane u_trig (
      .clk  (clk),
      .ctl  (ctl),
      .raw  (raw_trig[i]),
      .trig (trig[i])
    );
  end

  gic_merge u_merge (
    .clk         (clk),
    .ctl         (ctl),
    .low_pins    (in_low_active_pins),
    .high_pins   (in_high_active_pins),
    .stick       (stick),
    .trig        (trig),
    .press_level (level_r),
    .stick_out   (stick_o),
    .trig_out    (trig_o),
    .button_word (out_button_word)
  );

  assign out_stick_lx   = stick_o[0];
  assign out_stick_ly   = stick_o[1];
  assign out_stick_rx   = stick_o[2];
  assign out_stick_ry   = stick_o[3];
  assign out_trig_left  = trig_o[0];
  assign out_trig_right = trig_o[1];

endmodule

// ===== rtl/core/gic_checker.sv =====
// port-level checks for gamepad input conditioning, bound to the top level
// depends on gic_pkg and gamepad_input_conditioning_defines.svh
`include "gamepad_input_conditioning_defines.svh"

module gic_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [gic_pkg::SAMPLE_BITS-1:0]     in_raw_lx,
  input logic [gic_pkg::SAMPLE_BITS-1:0]     in_raw_ly,
  input logic [gic_pkg::SAMPLE_BITS-1:0]     in_raw_rx,
  input logic [gic_pkg::SAMPLE_BITS-1:0]     in_raw_ry,
  input logic [gic_pkg::SAMPLE_BITS-1:0]     in_raw_ltrig,
  input logic [gic_pkg::SAMPLE_BITS-1:0]     in_raw_rtrig,
  input logic [gic_pkg::LOW_PINS-1:0]        in_low_active_pins,
  input logic [gic_pkg::HIGH_PINS-1:0]       in_high_active_pins,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [gic_pkg::BYTE_BITS-1:0]       out_stick_lx,
  input logic [gic_pkg::BYTE_BITS-1:0]       out_stick_ly,
  input logic [gic_pkg::BYTE_BITS-1:0]       out_stick_rx,
  input logic [gic_pkg::BYTE_BITS-1:0]       out_stick_ry,
  input logic [gic_pkg::BYTE_BITS-1:0]       out_trig_left,
  input logic [gic_pkg::BYTE_BITS-1:0]       out_trig_right,
  input logic [gic_pkg::BUTTON_BITS-1:0]     out_button_word,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [gic_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input logic [gic_pkg::CAL_BITS-1:0]        cfg_data
);

  logic [6*gic_pkg::BYTE_BITS+gic_pkg::BUTTON_BITS-1:0] out_payload;
  logic held, out_free, trig_ok;

  assign out_payload = {out_stick_lx, out_stick_ly, out_stick_rx, out_stick_ry,
                        out_trig_left, out_trig_right, out_button_word};

  assign held     = out_valid && out_stall;
  assign out_free = !out_valid || !out_stall;
  assign trig_ok  = (out_trig_left <= gic_pkg::TRIG_OUT_MAX) &&
                    (out_trig_right <= gic_pkg::TRIG_OUT_MAX);

  `GIC_ASSERT_NEXT(a_out_hold, held, out_valid && $stable(out_payload), "stalled result changed")
  `GIC_ASSERT_SAME(a_no_false_stall, out_free, !in_stall, "input stalled with free output")
  `GIC_ASSERT_SAME(a_trig_range, out_valid, trig_ok, "trigger byte out of range")
  `GIC_ASSERT_SAME(a_reset_empty, $rose(rst_n), !out_valid, "result present after reset")

endmodule

bind gamepad_input_conditioning gic_checker u_gic_checker (.*);
